// ----- src/bnsm_pkg.sv -----
// bnsm_pkg: shared types, fixed-point constants and the arctangent table
// for the box net to sphere map block; no dependencies
package bnsm_pkg;

  localparam int CORDIC_STAGES   = 16;
  localparam int COORD_FRAC_BITS = 14;
  localparam int LEN_W           = 32;   // signed Q.20 lengths
  localparam int ANG_W           = 36;   // signed Q.30 radians
  localparam int QUEUE_DEPTH     = 4;

  localparam logic signed [ANG_W-1:0] PI_Q30       = 36'sd3373259426;
  localparam logic signed [ANG_W-1:0] HALF_PI_Q30  = 36'sd1686629713;
  localparam logic signed [31:0]      INV_PI_Q32   = 32'sd1367130551;
  localparam logic signed [31:0]      INV_GAIN_Q30 = 32'sd652032874;
  localparam logic [15:0]             EYE_ONE      = 16'd32768;

  typedef enum logic [2:0] {
    REG_BOX_X = 3'd0,
    REG_BOX_Y = 3'd1,
    REG_BOX_Z = 3'd2,
    REG_EYE_X = 3'd3,
    REG_EYE_Y = 3'd4,
    REG_EYE_Z = 3'd5
  } reg_idx_t;

  localparam logic [2:0] FACE_NADIR  = 3'd4;
  localparam logic [2:0] FACE_ZENITH = 3'd5;

  // geometry derived from the configuration registers
  typedef struct packed {
    logic [16:0]             s;
    logic signed [LEN_W-1:0] x_len;
    logic signed [LEN_W-1:0] y_len;
    logic signed [LEN_W-1:0] hz;
    logic signed [LEN_W-1:0] bxe;
    logic signed [LEN_W-1:0] bxe1;
    logic signed [LEN_W-1:0] bye;
    logic signed [LEN_W-1:0] bye1;
    logic signed [LEN_W-1:0] zoff;
    logic signed [LEN_W-1:0] zn;
    logic signed [LEN_W-1:0] zz;
    logic signed [LEN_W-1:0] y_bxe1;
    logic signed [LEN_W-1:0] bye1_x;
    logic signed [LEN_W-1:0] hz_x;
    logic signed [LEN_W-1:0] hz_bxe1;
    logic signed [ANG_W-1:0] h0;
  } cfg_t;

  // classified item handed from the front to the back
  typedef struct packed {
    logic signed [LEN_W-1:0] v1x;
    logic signed [LEN_W-1:0] v1y;
    logic signed [LEN_W-1:0] v2y;
    logic [2:0]              face;
    logic                    hit;
    logic                    neg_a;
    logic                    neg_v;
  } item_t;

  typedef struct packed {
    logic signed [LEN_W-1:0] v2y;
    logic [2:0]              face;
    logic                    hit;
    logic                    neg_a;
    logic                    neg_v;
  } pl1_t;

  typedef struct packed {
    logic signed [ANG_W-1:0] ang1;
    logic [2:0]              face;
    logic                    hit;
    logic                    neg_a;
    logic                    neg_v;
  } pl2_t;

  // arctangent of 2^-i in Q.30, truncated
  function automatic logic signed [ANG_W-1:0] atan_q30(input int i);
    logic signed [ANG_W-1:0] a;
    unique case (i)
      0:  a = 36'sd843314856;
      1:  a = 36'sd497837829;
      2:  a = 36'sd263043836;
      3:  a = 36'sd133525158;
      4:  a = 36'sd67021686;
      5:  a = 36'sd33543515;
      6:  a = 36'sd16775850;
      7:  a = 36'sd8388437;
      8:  a = 36'sd4194282;
      9:  a = 36'sd2097149;
      10: a = 36'sd1048575;
      11: a = 36'sd524287;
      12: a = 36'sd262143;
      13: a = 36'sd131071;
      14: a = 36'sd65535;
      15: a = 36'sd32767;
      16: a = 36'sd16383;
      17: a = 36'sd8191;
      18: a = 36'sd4095;
      19: a = 36'sd2047;
      20: a = 36'sd1023;
      21: a = 36'sd511;
      22: a = 36'sd255;
      23: a = 36'sd127;
      default: a = '0;
    endcase
    return a;
  endfunction

endpackage

// ----- src/box_net_to_sphere_map_core.sv -----
// box_net_to_sphere_map_core: top level of the box net to sphere map
// depends on bnsm_pkg, bnsm_cfg, bnsm_front, bnsm_fifo, bnsm_back
//
// Maps a normalised point on the unfolded net of a box to the angles it
// looks at on an equirectangular image, plus a face index and a hit flag.
// in_*:  stream of points; one item per point
// out_*: stream of results, exactly one per input item, in order
// cfg_*: register writes (box sizes, eye position), to be made only while
//   idle; the block does not enforce it. One item per cycle is sustained
// while out_tready stays high. Items pass the front stages, the queue, both
// cordic passes and the gain, sum, 1/pi and output registers in the back.
// A config write takes effect for items accepted from the next cycle on.
// Reset (synchronous, rst_n low) restores the default box and eye and
// empties every stage; no result is shown until new items arrive.
// A stalled receiver freezes the back end; the front keeps accepting into a
// four-item queue and lowers in_tready only once that queue is full and an
// item waits in its last stage.
module box_net_to_sphere_map_core #(
  parameter int CORDIC_STAGES   = bnsm_pkg::CORDIC_STAGES,
  parameter int COORD_FRAC_BITS = bnsm_pkg::COORD_FRAC_BITS
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // dest_x [15:0], dest_y [31:16]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // src_x [15:0], src_y [31:16]
  output logic [7:0]  out_tuser,  // hit [0], face [3:1], zero [7:4]
  input  logic        cfg_we,
  input  logic [2:0]  cfg_addr,
  input  logic [15:0] cfg_wdata
);

  bnsm_pkg::cfg_t  cfg;
  bnsm_pkg::item_t push_data, pop_data;
  logic push_valid, push_ready, pop_valid, pop_ready;

  bnsm_cfg #(.CORDIC_STAGES(CORDIC_STAGES)) u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  bnsm_front #(.COORD_FRAC_BITS(COORD_FRAC_BITS)) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data)
  );

  bnsm_fifo #(.W($bits(bnsm_pkg::item_t)), .DEPTH(bnsm_pkg::QUEUE_DEPTH)) u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_data   (pop_data)
  );

  bnsm_back #(
    .CORDIC_STAGES   (CORDIC_STAGES),
    .COORD_FRAC_BITS (COORD_FRAC_BITS)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .h0         (cfg.h0),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_data   (pop_data),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

`ifndef SYNTHESIS
  // a miss carries all-zero angles and face
  a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser[0] |-> out_tdata == 32'd0 && out_tuser[3:1] == 3'd0)
    else $error("miss result with non-zero payload");

  // a hit names one of the six faces
  a_face_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[0] |-> out_tuser[3:1] <= bnsm_pkg::FACE_ZENITH)
    else $error("face index out of range");

  // reset empties the output stage
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result shown right after reset");
`endif

endmodule

// ----- src/bnsm_cordic.sv -----
// bnsm_cordic: pipelined vectoring cordic giving angle and unscaled length
// depends on bnsm_pkg for angle width, pi and the arctangent table
module bnsm_cordic #(
  parameter int STAGES = bnsm_pkg::CORDIC_STAGES,
  parameter int W      = bnsm_pkg::LEN_W,
  parameter int PW     = 1
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             en,
  input  logic                             in_valid,
  input  logic signed [W-1:0]              in_x,
  input  logic signed [W-1:0]              in_y,
  input  logic [PW-1:0]                    in_pl,
  output logic                             out_valid,
  output logic signed [bnsm_pkg::ANG_W-1:0] out_ang,
  output logic signed [W-1:0]              out_x,
  output logic [PW-1:0]                    out_pl
);

  logic signed [W-1:0]               x_r  [0:STAGES];
  logic signed [W-1:0]               y_r  [0:STAGES];
  logic signed [bnsm_pkg::ANG_W-1:0] z_r  [0:STAGES];
  logic                              zf_r [0:STAGES];
  logic                              v_r  [0:STAGES];
  logic [PW-1:0]                     pl_r [0:STAGES];

  // pre-rotation into the right half plane, zero vector flagged
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r[0] <= 1'b0;
    end else if (en) begin
      v_r[0] <= in_valid;
    end
    if (en) begin
      zf_r[0] <= (in_x == '0) && (in_y == '0);
      pl_r[0] <= in_pl;
      if (in_x < 0) begin
        x_r[0] <= -in_x;
        y_r[0] <= -in_y;
        z_r[0] <= (in_y >= 0) ? bnsm_pkg::PI_Q30 : -bnsm_pkg::PI_Q30;
      end else begin
        x_r[0] <= in_x;
        y_r[0] <= in_y;
        z_r[0] <= '0;
      end
    end
  end

  // one micro-rotation per stage
  for (genvar k = 1; k <= STAGES; k++) begin : g_stage
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[k] <= 1'b0;
      end else if (en) begin
        v_r[k] <= v_r[k-1];
      end
      if (en) begin
        zf_r[k] <= zf_r[k-1];
        pl_r[k] <= pl_r[k-1];
        if (y_r[k-1] > 0) begin
          x_r[k] <= x_r[k-1] + (y_r[k-1] >>> (k-1));
          y_r[k] <= y_r[k-1] - (x_r[k-1] >>> (k-1));
          z_r[k] <= z_r[k-1] + bnsm_pkg::atan_q30(k-1);
        end else begin
          x_r[k] <= x_r[k-1] - (y_r[k-1] >>> (k-1));
          y_r[k] <= y_r[k-1] + (x_r[k-1] >>> (k-1));
          z_r[k] <= z_r[k-1] - bnsm_pkg::atan_q30(k-1);
        end
      end
    end
  end

  assign out_valid = v_r[STAGES];
  assign out_ang   = zf_r[STAGES] ? '0 : z_r[STAGES];
  assign out_x     = x_r[STAGES];
  assign out_pl    = pl_r[STAGES];

endmodule

// ----- src/bnsm_cfg.sv -----
// bnsm_cfg: configuration registers and the box geometry derived from them
// depends on bnsm_pkg and bnsm_cordic (eye heading angle)
module bnsm_cfg #(
  parameter int CORDIC_STAGES = bnsm_pkg::CORDIC_STAGES
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [2:0]           cfg_addr,
  input  logic [15:0]          cfg_wdata,
  output bnsm_pkg::cfg_t       cfg
);

  logic [15:0] box_x_r, box_y_r, box_z_r;
  logic [14:0] eye_x_r, eye_y_r, eye_z_r;
  bnsm_pkg::cfg_t d_r, d_nxt;
  logic signed [bnsm_pkg::ANG_W-1:0] a0;
  logic signed [16:0] ez;
  logic signed [33:0] zp;

  function automatic logic signed [bnsm_pkg::LEN_W-1:0] box_eye(
    input logic [15:0] b, input logic [15:0] e);
    logic [31:0] p;
    p = b * e;
    return $signed({7'b0, p[31:7]});
  endfunction

  // register writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      box_x_r <= 16'd4096;
      box_y_r <= 16'd4096;
      box_z_r <= 16'd4096;
      eye_x_r <= 15'd16384;
      eye_y_r <= 15'd16384;
      eye_z_r <= 15'd16384;
    end else if (cfg_we) begin
      unique case (bnsm_pkg::reg_idx_t'(cfg_addr))
        bnsm_pkg::REG_BOX_X: box_x_r <= cfg_wdata;
        bnsm_pkg::REG_BOX_Y: box_y_r <= cfg_wdata;
        bnsm_pkg::REG_BOX_Z: box_z_r <= cfg_wdata;
        bnsm_pkg::REG_EYE_X: eye_x_r <= cfg_wdata[14:0];
        bnsm_pkg::REG_EYE_Y: eye_y_r <= cfg_wdata[14:0];
        bnsm_pkg::REG_EYE_Z: eye_z_r <= cfg_wdata[14:0];
        default: ;
      endcase
    end
  end

  // derived lengths in Q.20
  always_comb begin
    ez = $signed({2'b0, eye_z_r}) - 17'sd16384;
    zp = ez * $signed({1'b0, box_z_r});
    d_nxt        = '0;
    d_nxt.s      = {1'b0, box_x_r} + {1'b0, box_y_r};
    d_nxt.x_len  = $signed({8'b0, box_x_r, 8'b0});
    d_nxt.y_len  = $signed({8'b0, box_y_r, 8'b0});
    d_nxt.hz     = $signed({9'b0, box_z_r, 7'b0});
    d_nxt.bxe    = box_eye(box_x_r, {1'b0, eye_x_r});
    d_nxt.bxe1   = box_eye(box_x_r, bnsm_pkg::EYE_ONE - {1'b0, eye_x_r});
    d_nxt.bye    = box_eye(box_y_r, {1'b0, eye_y_r});
    d_nxt.bye1   = box_eye(box_y_r, bnsm_pkg::EYE_ONE - {1'b0, eye_y_r});
    d_nxt.zoff   = bnsm_pkg::LEN_W'(zp >>> 7);
    d_nxt.zn     = box_eye(box_z_r, {1'b0, eye_z_r});
    d_nxt.zz     = box_eye(box_z_r, bnsm_pkg::EYE_ONE - {1'b0, eye_z_r});
    d_nxt.y_bxe1  = d_nxt.y_len + d_nxt.bxe1;
    d_nxt.bye1_x  = d_nxt.bye1 + d_nxt.x_len;
    d_nxt.hz_x    = d_nxt.hz + d_nxt.x_len;
    d_nxt.hz_bxe1 = d_nxt.hz + d_nxt.bxe1;
  end

  always_ff @(posedge clk) begin
    d_r <= d_nxt;
  end

  // heading of the eye seen from the box corner, free running
  bnsm_cordic #(
    .STAGES (CORDIC_STAGES),
    .W      (bnsm_pkg::LEN_W),
    .PW     (1)
  ) u_h0 (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (1'b1),
    .in_valid  (1'b1),
    .in_x      (d_r.bye),
    .in_y      (d_r.bxe),
    .in_pl     (1'b0),
    .out_valid (),
    .out_ang   (a0),
    .out_x     (),
    .out_pl    ()
  );

  always_comb begin
    cfg    = d_r;
    cfg.s  = d_nxt.s;
    cfg.h0 = a0 - bnsm_pkg::PI_Q30;
  end

endmodule

// ----- src/bnsm_front.sv -----
// bnsm_front: accepts destination points, scales them and picks the face
// depends on bnsm_pkg (cfg_t, item_t, face codes)
module bnsm_front #(
  parameter int COORD_FRAC_BITS = bnsm_pkg::COORD_FRAC_BITS
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  bnsm_pkg::cfg_t       cfg,
  input  logic                 in_tvalid,
  output logic                 in_tready,
  input  logic [31:0]          in_tdata,
  output logic                 push_valid,
  input  logic                 push_ready,
  output bnsm_pkg::item_t      push_data
);

  localparam int DN = COORD_FRAC_BITS + 12;

  logic fen;
  logic a_valid_r, b_valid_r;
  logic signed [bnsm_pkg::LEN_W-1:0] dx_r, dy_r;
  logic signed [bnsm_pkg::LEN_W-1:0] dx_nxt, dy_nxt, dy2;
  logic signed [32:0] px, py;
  logic signed [52:0] ex, ey;
  logic side, dx_in, nadir, zenith;
  bnsm_pkg::item_t b_r, b_nxt;

  assign fen       = !b_valid_r || push_ready;
  assign in_tready = fen;

  // scale by box_x + box_y, floor to Q.20
  always_comb begin
    px = $signed(in_tdata[15:0]) * $signed({1'b0, cfg.s});
    py = $signed(in_tdata[31:16]) * $signed({1'b0, cfg.s});
    ex = $signed({px, 20'b0}) >>> DN;
    ey = $signed({py, 20'b0}) >>> DN;
    dx_nxt = bnsm_pkg::LEN_W'(ex);
    dy_nxt = bnsm_pkg::LEN_W'(ey);
  end

  // face classification and view vectors
  always_comb begin
    side   = (dy_r >= -cfg.hz) && (dy_r <= cfg.hz);
    dx_in  = (dx_r > -cfg.y_len) && (dx_r < 0);
    nadir  = (dy_r > cfg.hz) && (dy_r < cfg.hz_x) && dx_in;
    zenith = (dy_r > -cfg.hz_x) && (dy_r < -cfg.hz) && dx_in;
    dy2    = dy_r + cfg.zoff;
    b_nxt  = '0;
    priority if (side) begin
      b_nxt.hit = 1'b1;
      b_nxt.v2y = dy2;
      priority if (dx_r < -cfg.y_len) begin
        b_nxt.face = 3'd0;
        b_nxt.v1y  = dx_r + cfg.y_bxe1;
        b_nxt.v1x  = cfg.bye;
      end else if (dx_r < 0) begin
        b_nxt.face = 3'd1;
        b_nxt.v1y  = dx_r + cfg.bye1;
        b_nxt.v1x  = cfg.bxe1;
      end else if (dx_r < cfg.x_len) begin
        b_nxt.face = 3'd2;
        b_nxt.v1y  = dx_r - cfg.bxe1;
        b_nxt.v1x  = cfg.bye1;
      end else begin
        b_nxt.face = 3'd3;
        b_nxt.v1y  = dx_r - cfg.bye1_x;
        b_nxt.v1x  = cfg.bxe;
      end
    end else if (nadir) begin
      b_nxt.hit  = 1'b1;
      b_nxt.face = bnsm_pkg::FACE_NADIR;
      b_nxt.v1x  = dx_r + cfg.bye1;
      b_nxt.v1y  = dy_r - cfg.hz_bxe1;
      b_nxt.v2y  = cfg.zn;
    end else if (zenith) begin
      b_nxt.hit   = 1'b1;
      b_nxt.face  = bnsm_pkg::FACE_ZENITH;
      b_nxt.v1x   = dx_r + cfg.bye1;
      b_nxt.v1y   = dy_r + cfg.hz_bxe1;
      b_nxt.v2y   = cfg.zz;
      b_nxt.neg_a = 1'b1;
      b_nxt.neg_v = 1'b1;
    end else begin
      b_nxt.hit = 1'b0;
    end
  end

  // two front stages, stalled together when the queue is full and the last holds an item
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r <= 1'b0;
      b_valid_r <= 1'b0;
    end else if (fen) begin
      a_valid_r <= in_tvalid;
      b_valid_r <= a_valid_r;
    end
    if (fen) begin
      dx_r <= dx_nxt;
      dy_r <= dy_nxt;
      b_r  <= b_nxt;
    end
  end

  assign push_valid = b_valid_r;
  assign push_data  = b_r;

endmodule

// ----- src/bnsm_fifo.sv -----
// bnsm_fifo: short register queue between the front and the back
// no dependencies besides its parameters
module bnsm_fifo #(
  parameter int W     = 8,
  parameter int DEPTH = 4
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         push_valid,
  output logic         push_ready,
  input  logic [W-1:0] push_data,
  output logic         pop_valid,
  input  logic         pop_ready,
  output logic [W-1:0] pop_data
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam logic [AW:0]   FULL_CNT = (AW+1)'(DEPTH);
  localparam logic [AW-1:0] LAST     = AW'(DEPTH - 1);

  logic [W-1:0]  mem_r [0:DEPTH-1];
  logic [AW-1:0] wp_r, rp_r;
  logic [AW:0]   cnt_r;
  logic          do_push, do_pop;

  assign push_ready = (cnt_r != FULL_CNT);
  assign pop_valid  = (cnt_r != '0);
  assign pop_data   = mem_r[rp_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (do_push) wp_r <= (wp_r == LAST) ? '0 : wp_r + 1'b1;
      if (do_pop)  rp_r <= (rp_r == LAST) ? '0 : rp_r + 1'b1;
      if (do_push && !do_pop) cnt_r <= cnt_r + 1'b1;
      else if (do_pop && !do_push) cnt_r <= cnt_r - 1'b1;
    end
    if (do_push) mem_r[wp_r] <= push_data;
  end

endmodule

// ----- src/bnsm_back.sv -----
// bnsm_back: two cordic passes, angle sums, scaling by 1/pi and output register
// depends on bnsm_pkg and bnsm_cordic
module bnsm_back #(
  parameter int CORDIC_STAGES   = bnsm_pkg::CORDIC_STAGES,
  parameter int COORD_FRAC_BITS = bnsm_pkg::COORD_FRAC_BITS
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic signed [bnsm_pkg::ANG_W-1:0] h0,
  input  logic                              pop_valid,
  output logic                              pop_ready,
  input  bnsm_pkg::item_t                   pop_data,
  output logic                              out_tvalid,
  input  logic                              out_tready,
  output logic [31:0]                       out_tdata,
  output logic [7:0]                        out_tuser
);

  localparam int SH = 54 - COORD_FRAC_BITS;
  localparam int LW = bnsm_pkg::LEN_W;
  localparam int AW = bnsm_pkg::ANG_W;

  logic en;
  bnsm_pkg::pl1_t pl1_in, pl1_out, g_pl_r;
  bnsm_pkg::pl2_t pl2_in, pl2_out, h_pl_r, t_pl_r;
  logic c1_valid, c2_valid, g_valid_r, h_valid_r, t_valid_r, out_valid_r;
  logic signed [AW-1:0] ang1, ang2, g_ang_r, h_r, v_r, k_ang, a_sel;
  logic signed [LW-1:0] x1, m;
  logic signed [63:0]   g_p_r, m_full, th_r, tv_r;
  logic signed [27:0]   hs, vs;
  logic [15:0] src_x_r, src_y_r;
  logic        hit_r;
  logic [2:0]  face_r;

  assign en        = !out_valid_r || out_tready;
  assign pop_ready = en;

  function automatic logic [15:0] to_out(input logic signed [63:0] t);
    logic signed [63:0] r;
    r = (t + (64'sd1 <<< (SH - 1))) >>> SH;
    if (r > 64'sd32767) return 16'h7fff;
    else if (r < -64'sd32768) return 16'h8000;
    else return r[15:0];
  endfunction

  // horizontal angle and distance on the face plane
  always_comb begin
    pl1_in       = '0;
    pl1_in.v2y   = pop_data.v2y;
    pl1_in.face  = pop_data.face;
    pl1_in.hit   = pop_data.hit;
    pl1_in.neg_a = pop_data.neg_a;
    pl1_in.neg_v = pop_data.neg_v;
  end

  bnsm_cordic #(.STAGES(CORDIC_STAGES), .W(LW), .PW($bits(bnsm_pkg::pl1_t))) u_c1 (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (pop_valid),
    .in_x      (pop_data.v1x),
    .in_y      (pop_data.v1y),
    .in_pl     (pl1_in),
    .out_valid (c1_valid),
    .out_ang   (ang1),
    .out_x     (x1),
    .out_pl    (pl1_out)
  );

  // cordic gain correction
  always_ff @(posedge clk) begin
    if (!rst_n) g_valid_r <= 1'b0;
    else if (en) g_valid_r <= c1_valid;
    if (en) begin
      g_p_r   <= x1 * bnsm_pkg::INV_GAIN_Q30;
      g_ang_r <= ang1;
      g_pl_r  <= pl1_out;
    end
  end

  always_comb begin
    m_full = g_p_r >>> 30;
    m      = m_full[63] ? '0 : m_full[LW-1:0];
    pl2_in       = '0;
    pl2_in.ang1  = g_ang_r;
    pl2_in.face  = g_pl_r.face;
    pl2_in.hit   = g_pl_r.hit;
    pl2_in.neg_a = g_pl_r.neg_a;
    pl2_in.neg_v = g_pl_r.neg_v;
  end

  // vertical angle over the ground distance
  bnsm_cordic #(.STAGES(CORDIC_STAGES), .W(LW), .PW($bits(bnsm_pkg::pl2_t))) u_c2 (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (g_valid_r),
    .in_x      (m),
    .in_y      (g_pl_r.v2y),
    .in_pl     (pl2_in),
    .out_valid (c2_valid),
    .out_ang   (ang2),
    .out_x     (),
    .out_pl    (pl2_out)
  );

  // face offset for the horizontal angle
  always_comb begin
    unique case (pl2_out.face)
      3'd0:    k_ang = '0;
      3'd1:    k_ang = bnsm_pkg::HALF_PI_Q30;
      3'd3:    k_ang = bnsm_pkg::HALF_PI_Q30 + bnsm_pkg::PI_Q30;
      default: k_ang = bnsm_pkg::PI_Q30;
    endcase
    a_sel = pl2_out.neg_a ? -pl2_out.ang1 : pl2_out.ang1;
  end

  // angle sums
  always_ff @(posedge clk) begin
    if (!rst_n) h_valid_r <= 1'b0;
    else if (en) h_valid_r <= c2_valid;
    if (en) begin
      h_r    <= a_sel + h0 + k_ang;
      v_r    <= pl2_out.neg_v ? -ang2 : ang2;
      h_pl_r <= pl2_out;
    end
  end

  // scale by 1/pi
  assign hs = 28'(h_r >>> 8);
  assign vs = 28'(v_r >>> 8);

  always_ff @(posedge clk) begin
    if (!rst_n) t_valid_r <= 1'b0;
    else if (en) t_valid_r <= h_valid_r;
    if (en) begin
      th_r   <= hs * bnsm_pkg::INV_PI_Q32;
      tv_r   <= vs * bnsm_pkg::INV_PI_Q32;
      t_pl_r <= h_pl_r;
    end
  end

  // rounding, saturation and output register
  always_ff @(posedge clk) begin
    if (!rst_n) out_valid_r <= 1'b0;
    else if (en) out_valid_r <= t_valid_r;
    if (en) begin
      hit_r   <= t_pl_r.hit;
      face_r  <= t_pl_r.hit ? t_pl_r.face : 3'd0;
      src_x_r <= t_pl_r.hit ? to_out(th_r) : 16'd0;
      src_y_r <= t_pl_r.hit ? to_out(tv_r) : 16'd0;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {src_y_r, src_x_r};
  assign out_tuser  = {4'b0, face_r, hit_r};

endmodule
